@@ rtl/cftc_pkg.sv @@
// shared types, constants and recognizer functions for the csv field type classifier
package cftc_pkg;

    // column counter saturation
    localparam int MAX_COLUMNS = 256;
    localparam int COL_LIMIT   = (MAX_COLUMNS - 1 < 255) ? (MAX_COLUMNS - 1) : 255;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // magnitude limit for the signed 64-bit range
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

    // character codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_L  = 8'h6C;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_U  = 8'h75;

    // result type codes
    typedef enum logic [2:0] {
        TY_STRING = 3'd0,
        TY_INT    = 3'd1,
        TY_FLOAT  = 3'd2,
        TY_BOOL   = 3'd3,
        TY_EMPTY  = 3'd4
    } type_code_t;

    // token class recognizer states
    typedef enum logic [3:0] {
        CL_OUTSIDE  = 4'd0,
        CL_SIGN     = 4'd1,
        CL_INT      = 4'd2,
        CL_FRAC     = 4'd3,
        CL_EXP_E    = 4'd4,
        CL_EXP_REST = 4'd5,
        CL_STR      = 4'd6,
        CL_DONE     = 4'd7
    } cls_state_t;

    // true/false matcher states
    typedef enum logic [3:0] {
        WM_START = 4'd0,
        WM_T     = 4'd1,
        WM_TR    = 4'd2,
        WM_TRU   = 4'd3,
        WM_TRUE  = 4'd4,
        WM_F     = 4'd5,
        WM_FA    = 4'd6,
        WM_FAL   = 4'd7,
        WM_FALS  = 4'd8,
        WM_FALSE = 4'd9,
        WM_FAIL  = 4'd15
    } wm_state_t;

    // one finished token as it travels from front to back
    typedef struct packed {
        type_code_t  type_code;
        logic [7:0]  column;
        logic [31:0] row;
        logic        negative;
        logic        overflow;
        logic [63:0] magnitude;
        logic        last;
    } tok_word_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // class step; fresh means the byte opens a new token
    function automatic cls_state_t class_step(input cls_state_t cls, input logic [7:0] c,
                                              input logic fresh);
        cls_state_t n;
        n = CL_STR;
        if (fresh) begin
            if (is_sign(c)) n = CL_SIGN;
            else if (is_digit(c)) n = CL_INT;
            else n = CL_STR;
        end else begin
            unique case (cls)
                CL_SIGN, CL_INT: begin
                    if (is_digit(c)) n = CL_INT;
                    else if (c == CH_POINT && cls == CL_INT) n = CL_FRAC;
                    else n = CL_STR;
                end
                CL_FRAC: begin
                    if (c == CH_LO_E || c == CH_UP_E) n = CL_EXP_E;
                    else if (!is_digit(c)) n = CL_STR;
                    else n = CL_FRAC;
                end
                CL_EXP_E: n = (is_sign(c) || is_digit(c)) ? CL_EXP_REST : CL_STR;
                CL_EXP_REST: n = is_digit(c) ? CL_EXP_REST : CL_STR;
                default: n = CL_STR;
            endcase
        end
        return n;
    endfunction

    // case-insensitive match of true and false
    function automatic wm_state_t word_step(input wm_state_t w, input logic [7:0] c);
        logic [7:0] lc;
        wm_state_t  n;
        lc = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CH_CASE) : c;
        n  = WM_FAIL;
        if (w == WM_START && lc == CH_LO_T) n = WM_T;
        else if (w == WM_T && lc == CH_LO_R) n = WM_TR;
        else if (w == WM_TR && lc == CH_LO_U) n = WM_TRU;
        else if (w == WM_TRU && lc == CH_LO_E) n = WM_TRUE;
        else if (w == WM_START && lc == CH_LO_F) n = WM_F;
        else if (w == WM_F && lc == CH_LO_A) n = WM_FA;
        else if (w == WM_FA && lc == CH_LO_L) n = WM_FAL;
        else if (w == WM_FAL && lc == CH_LO_S) n = WM_FALS;
        else if (w == WM_FALS && lc == CH_LO_E) n = WM_FALSE;
        return n;
    endfunction

    // type of the token that is open or held
    function automatic type_code_t final_type(input cls_state_t cls, input wm_state_t w,
                                              input type_code_t held);
        type_code_t t;
        if (cls == CL_DONE) t = held;
        else if (cls == CL_INT) t = TY_INT;
        else if (cls == CL_FRAC || cls == CL_EXP_E || cls == CL_EXP_REST) t = TY_FLOAT;
        else if (w == WM_TRUE || w == WM_FALSE) t = TY_BOOL;
        else t = TY_STRING;
        return t;
    endfunction

endpackage

@@ rtl/csv_field_type_classifier.sv @@
// top level: csv tokenizer with type inference, front recognizer, token queue, output stage
// throughput: one input word per cycle while the token queue has room (s_ready follows it),
//   set by the combinational recognizer and decimal accumulator in the front end
// path: the word that releases a result (next token's first byte or end of line) writes it
//   into the queue as it is accepted; the result then moves to the output register when the
//   output stage is free, so m_ready back-pressure can hold it in the queue
// reset: synchronous active-low aresetn clears recognizer state, counters, queue and valid
module csv_field_type_classifier (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [7:0]         s_char_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_type_code,
    output logic [7:0]         m_column_index,
    output logic [31:0]        m_row_index,
    output logic signed [63:0] m_int_value,
    output logic               m_last_in_row
);

    logic                push_valid;
    logic                push_ready;
    cftc_pkg::tok_word_t push_word;
    logic                q_valid;
    logic                q_ready;
    cftc_pkg::tok_word_t q_word;

    cftc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_word   (push_word)
    );

    cftc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_word   (push_word),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_word  (q_word)
    );

    cftc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_word         (q_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_type_code    (m_type_code),
        .m_column_index (m_column_index),
        .m_row_index    (m_row_index),
        .m_int_value    (m_int_value),
        .m_last_in_row  (m_last_in_row)
    );

    // end of line always produces a token word into the queue
    a_eol_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind) |-> push_valid)
        else $error("end of line did not produce a token word");

    // empty row word is the last of its row at column zero
    a_empty_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_type_code == cftc_pkg::TY_EMPTY) |->
        (m_last_in_row && m_column_index == 8'd0))
        else $error("empty row word malformed");

    // value is zero for every type but integer
    a_int_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_type_code != cftc_pkg::TY_INT) |-> (m_int_value == 64'sd0))
        else $error("nonzero value on a non-integer word");

    // a queued word reaches the output stage whenever the output is free
    a_back_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !m_valid) |=> m_valid)
        else $error("queued word did not move to the output");

endmodule

@@ rtl/cftc_front.sv @@
// front end: takes characters, tracks token class and integer value, emits finished tokens
module cftc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [7:0]          s_char_code,
    output logic                push_valid,
    input  logic                push_ready,
    output cftc_pkg::tok_word_t push_word
);

    cftc_pkg::cls_state_t cls_reg, cls_next;
    cftc_pkg::wm_state_t  word_reg, word_next;
    cftc_pkg::type_code_t held_reg, held_next;
    logic                 neg_reg, neg_next;
    logic                 ovf_reg, ovf_next;
    logic [63:0]          acc_reg, acc_next;
    logic [7:0]           col_reg, col_next;
    logic [31:0]          row_reg, row_next;

    logic        accept;
    logic        is_sep;
    logic        start_tok;
    logic        digit_add;
    logic [63:0] base_acc;
    logic        base_ovf;
    logic [67:0] acc_sum;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    // byte decode
    assign is_sep    = !s_kind && (s_char_code == cftc_pkg::CH_COMMA ||
                                   s_char_code == cftc_pkg::CH_SPACE);
    assign start_tok = !s_kind && !is_sep &&
                       (cls_reg == cftc_pkg::CL_DONE || cls_reg == cftc_pkg::CL_OUTSIDE);
    assign digit_add = cftc_pkg::is_digit(s_char_code) &&
                       (start_tok || cls_reg == cftc_pkg::CL_SIGN ||
                        cls_reg == cftc_pkg::CL_INT);

    // decimal accumulate: base * 10 + digit
    assign base_acc = start_tok ? 64'd0 : acc_reg;
    assign base_ovf = start_tok ? 1'b0 : ovf_reg;
    assign acc_sum  = ({4'd0, base_acc} << 3) + ({4'd0, base_acc} << 1) +
                      {60'd0, s_char_code[3:0]};

    // next state
    always_comb begin
        cls_next  = cls_reg;
        word_next = word_reg;
        held_next = held_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        acc_next  = acc_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            if (s_kind) begin
                row_next  = row_reg + 32'd1;
                cls_next  = cftc_pkg::CL_OUTSIDE;
                word_next = cftc_pkg::WM_START;
                held_next = cftc_pkg::TY_STRING;
                neg_next  = 1'b0;
                ovf_next  = 1'b0;
                acc_next  = 64'd0;
                col_next  = 8'd0;
            end else if (is_sep) begin
                if (cls_reg != cftc_pkg::CL_OUTSIDE && cls_reg != cftc_pkg::CL_DONE) begin
                    held_next = cftc_pkg::final_type(cls_reg, word_reg, held_reg);
                    cls_next  = cftc_pkg::CL_DONE;
                end
            end else begin
                if (cls_reg == cftc_pkg::CL_DONE) begin
                    if (col_reg < 8'(cftc_pkg::COL_LIMIT)) col_next = col_reg + 8'd1;
                end else if (cls_reg == cftc_pkg::CL_OUTSIDE) begin
                    col_next = 8'd0;
                end
                cls_next  = cftc_pkg::class_step(cls_reg, s_char_code, start_tok);
                word_next = cftc_pkg::word_step(start_tok ? cftc_pkg::WM_START : word_reg,
                                                s_char_code);
                if (start_tok) neg_next = (s_char_code == cftc_pkg::CH_MINUS);
                acc_next = base_acc;
                ovf_next = base_ovf;
                if (digit_add && !base_ovf) begin
                    if (acc_sum > {4'd0, cftc_pkg::MAG_LIMIT}) ovf_next = 1'b1;
                    else acc_next = acc_sum[63:0];
                end
            end
        end
    end

    // outputs: a token leaves on end of line or when the next token opens
    always_comb begin
        push_valid = accept && (s_kind || (!is_sep && cls_reg == cftc_pkg::CL_DONE));
        if (s_kind && cls_reg == cftc_pkg::CL_OUTSIDE) begin
            push_word.type_code = cftc_pkg::TY_EMPTY;
            push_word.column    = 8'd0;
        end else begin
            push_word.type_code = cftc_pkg::final_type(cls_reg, word_reg, held_reg);
            push_word.column    = col_reg;
        end
        push_word.row       = row_reg;
        push_word.negative  = neg_reg;
        push_word.overflow  = ovf_reg;
        push_word.magnitude = acc_reg;
        push_word.last      = s_kind;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_reg  <= cftc_pkg::CL_OUTSIDE;
            word_reg <= cftc_pkg::WM_START;
            held_reg <= cftc_pkg::TY_STRING;
            neg_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            acc_reg  <= 64'd0;
            col_reg  <= 8'd0;
            row_reg  <= 32'd0;
        end else begin
            cls_reg  <= cls_next;
            word_reg <= word_next;
            held_reg <= held_next;
            neg_reg  <= neg_next;
            ovf_reg  <= ovf_next;
            acc_reg  <= acc_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

@@ rtl/cftc_queue.sv @@
// short token queue between front and back
module cftc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cftc_pkg::tok_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output cftc_pkg::tok_word_t out_word
);

    cftc_pkg::tok_word_t mem [cftc_pkg::QUEUE_DEPTH];

    logic [cftc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cftc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cftc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        push;
    logic                        pop;

    assign in_ready  = (count_reg != cftc_pkg::QCNT_W'(cftc_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == cftc_pkg::QPTR_W'(cftc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == cftc_pkg::QPTR_W'(cftc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= in_word;
    end

endmodule

@@ rtl/cftc_back.sv @@
// back end: forms the saturated integer value and holds the result word for the sink
module cftc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  cftc_pkg::tok_word_t q_word,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_type_code,
    output logic [7:0]          m_column_index,
    output logic [31:0]         m_row_index,
    output logic signed [63:0]  m_int_value,
    output logic                m_last_in_row
);

    logic               valid_reg, valid_next;
    logic [2:0]         type_reg;
    logic [7:0]         col_reg;
    logic [31:0]        row_reg;
    logic signed [63:0] int_reg;
    logic               last_reg;
    logic [63:0]        int_bits;
    logic               load;

    assign q_ready = !valid_reg || m_ready;
    assign load    = q_valid && q_ready;

    // signed value with saturation, zero unless integer
    always_comb begin
        if (q_word.negative) begin
            int_bits = q_word.overflow ? cftc_pkg::MAG_LIMIT : (~q_word.magnitude + 64'd1);
        end else begin
            int_bits = (q_word.overflow || q_word.magnitude[63]) ?
                       (cftc_pkg::MAG_LIMIT - 64'd1) : q_word.magnitude;
        end
        if (q_word.type_code != cftc_pkg::TY_INT) int_bits = 64'd0;
    end

    // output valid
    always_comb begin
        valid_next = valid_reg;
        if (load) valid_next = 1'b1;
        else if (m_ready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            type_reg <= q_word.type_code;
            col_reg  <= q_word.column;
            row_reg  <= q_word.row;
            int_reg  <= $signed(int_bits);
            last_reg <= q_word.last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_type_code    = type_reg;
    assign m_column_index = col_reg;
    assign m_row_index    = row_reg;
    assign m_int_value    = int_reg;
    assign m_last_in_row  = last_reg;

endmodule
